// ----- sv/i64alu_pkg.sv -----
`default_nettype none
package i64alu_pkg;

  localparam int ALU_W  = 64;
  localparam int HALF_W = ALU_W / 2;
  localparam int CNT_W  = $clog2(ALU_W);
  localparam int IN_TDATA_W  = 2 * ALU_W;
  localparam int IN_TUSER_W  = 5;
  localparam int OUT_TDATA_W = 72;
  localparam int OUT_PAD_W   = OUT_TDATA_W - ALU_W - 3;

  localparam logic [ALU_W-1:0] SIGN_BIT = {1'b1, {(ALU_W-1){1'b0}}};

  typedef enum logic [3:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_POW, OP_NEG, OP_AND,
    OP_OR, OP_XOR, OP_NOT, OP_SHL, OP_SHR, OP_EQ, OP_LT, OP_LE
  } op_t;

  typedef enum logic [1:0] {
    ERR_NONE, ERR_DIV0, ERR_NEGEXP, ERR_NEGRANGE
  } err_t;

  typedef enum logic [1:0] {
    K_MUL, K_DIV, K_POW
  } kind_t;

  typedef enum logic [2:0] {
    C_IDLE, C_MUL, C_DIV, C_PBIT, C_PACC, C_PSQR, C_DONE
  } cst_t;

  typedef enum logic [1:0] {
    S_IDLE, S_EXEC, S_WAIT, S_DONE
  } st_t;

  typedef struct packed {
    logic  start;
    kind_t kind;
  } core_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_rsp_t;

  typedef struct packed {
    logic [ALU_W-1:0] value;
    logic             value_signed;
    logic             truth;
    err_t             error;
  } res_t;

  function automatic logic [ALU_W-1:0] neg(input logic [ALU_W-1:0] x);
    return '0 - x;
  endfunction

endpackage
`default_nettype wire

// ----- sv/i64alu_core.sv -----
`default_nettype none
module i64alu_core (
  input  wire                        clk,
  input  wire                        rst_n,
  input  i64alu_pkg::core_req_t      req,
  input  wire [i64alu_pkg::ALU_W-1:0] x,
  input  wire [i64alu_pkg::ALU_W-1:0] y,
  output i64alu_pkg::core_rsp_t      rsp,
  output logic [i64alu_pkg::ALU_W-1:0] q,
  output logic [i64alu_pkg::ALU_W-1:0] r
);
  import i64alu_pkg::*;

  cst_t st_r, st_nxt;
  kind_t kind_r;
  logic [ALU_W-1:0] mx_r, my_r, prod_r, acc_r, base_r, ex_r, quo_r, rem_r, dv_r;
  logic [1:0] step_r;
  logic [CNT_W-1:0] cnt_r;

  logic [HALF_W-1:0] opx, opy;
  logic [ALU_W-1:0] pp, prod_nxt, rem_nxt;
  logic [ALU_W:0] rem_sh, diff;
  logic mul_last, ge;

  // one 32x32 partial product per cycle, low half of the 64x64 product in three steps
  always_comb begin
    opx = (step_r == 2'd2) ? mx_r[ALU_W-1:HALF_W] : mx_r[HALF_W-1:0];
    opy = (step_r == 2'd1) ? my_r[ALU_W-1:HALF_W] : my_r[HALF_W-1:0];
    pp = {{HALF_W{1'b0}}, opx} * {{HALF_W{1'b0}}, opy};
    prod_nxt = (step_r == 2'd0) ? pp : prod_r + {pp[HALF_W-1:0], {HALF_W{1'b0}}};
    mul_last = (step_r == 2'd2);
  end

  // restoring divide, one quotient bit a cycle
  always_comb begin
    rem_sh = {rem_r, quo_r[ALU_W-1]};
    diff = rem_sh - {1'b0, dv_r};
    ge = ~diff[ALU_W];
    rem_nxt = ge ? diff[ALU_W-1:0] : rem_sh[ALU_W-1:0];
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      C_IDLE: begin
        if (req.start) begin
          unique case (req.kind)
            K_MUL:   st_nxt = C_MUL;
            K_DIV:   st_nxt = C_DIV;
            default: st_nxt = C_PBIT;
          endcase
        end
      end
      C_MUL:  if (mul_last) st_nxt = C_DONE;
      C_DIV:  if (cnt_r == CNT_W'(ALU_W - 1)) st_nxt = C_DONE;
      C_PBIT: begin
        if (ex_r == '0) st_nxt = C_DONE;
        else if (ex_r[0]) st_nxt = C_PACC;
        else st_nxt = C_PSQR;
      end
      C_PACC: if (mul_last) st_nxt = C_PSQR;
      C_PSQR: if (mul_last) st_nxt = C_PBIT;
      C_DONE: st_nxt = C_IDLE;
      default: st_nxt = C_IDLE;
    endcase
  end

  always_comb begin
    rsp.busy = (st_r != C_IDLE);
    rsp.done = (st_r == C_DONE);
    r = rem_r;
    case (kind_r)
      K_MUL:   q = prod_r;
      K_DIV:   q = quo_r;
      default: q = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= C_IDLE;
    else st_r <= st_nxt;
  end

  always_ff @(posedge clk) begin
    case (st_r)
      C_IDLE: begin
        if (req.start) begin
          kind_r <= req.kind;
          mx_r <= x;
          my_r <= y;
          step_r <= 2'd0;
          acc_r <= {{(ALU_W-1){1'b0}}, 1'b1};
          base_r <= x;
          ex_r <= y;
          quo_r <= x;
          rem_r <= '0;
          dv_r <= y;
          cnt_r <= '0;
        end
      end
      C_MUL: begin
        prod_r <= prod_nxt;
        step_r <= step_r + 2'd1;
      end
      C_DIV: begin
        rem_r <= rem_nxt;
        quo_r <= {quo_r[ALU_W-2:0], ge};
        cnt_r <= cnt_r + CNT_W'(1);
      end
      C_PBIT: begin
        step_r <= 2'd0;
        mx_r <= ex_r[0] ? acc_r : base_r;
        my_r <= base_r;
      end
      C_PACC: begin
        prod_r <= prod_nxt;
        if (mul_last) begin
          acc_r <= prod_nxt;
          mx_r <= base_r;
          my_r <= base_r;
          step_r <= 2'd0;
        end else begin
          step_r <= step_r + 2'd1;
        end
      end
      C_PSQR: begin
        prod_r <= prod_nxt;
        step_r <= step_r + 2'd1;
        if (mul_last) begin
          base_r <= prod_nxt;
          ex_r <= ex_r >> 1;
        end
      end
      default: ;
    endcase
  end

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> st_r == C_IDLE) else $error("start while core busy");
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == C_DIV |-> dv_r != '0) else $error("divide with zero divisor");
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == C_MUL || st_r == C_PACC || st_r == C_PSQR) |-> step_r != 2'd3)
    else $error("multiply step out of range");

endmodule
`default_nettype wire

// ----- sv/int64_uint64_alu_unit.sv -----
`default_nettype none
// 64-bit integer alu, signed or unsigned mode per beat. one beat in, one beat out;
// a new beat is taken only once the previous one has moved into the output register.
// add/sub/logic/shift/compare/negate and error cases finish without the core; mul takes
// three 32x32 partial products on the shared multiplier; div and mod run in the
// shift-subtract unit, one quotient bit a cycle; pow does a square for every exponent bit
// up to its highest set bit and a multiply for each set bit, on the shared multiplier.
// results wait in the output register while the next beat is already being worked on.
module int64_uint64_alu_unit (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire [127:0] in_tdata,   // operand_a [63:0], operand_b [127:64]
  input  wire [4:0]   in_tuser,   // cmd [3:0], signed_mode [4]
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [71:0] out_tdata,  // value [63:0], truth [64], error [66:65], zero pad
  output logic        out_tuser   // value_signed
);
  import i64alu_pkg::*;

  st_t st_r, st_nxt;
  op_t cmd_r;
  logic sm_r;
  logic [ALU_W-1:0] a_r, b_r;
  res_t res_r, out_r;
  logic out_valid_r;

  core_req_t req;
  core_rsp_t rsp;
  logic [ALU_W-1:0] core_q, core_r;

  logic na, nb, need_core, out_free, shift_big;
  logic [ALU_W-1:0] ma, mb, sx;
  kind_t kind;
  res_t simple, cres;

  // magnitudes feed the divider, sign fixup afterwards
  always_comb begin
    na = a_r[ALU_W-1];
    nb = b_r[ALU_W-1];
    ma = (sm_r && na) ? neg(a_r) : a_r;
    mb = (sm_r && nb) ? neg(b_r) : b_r;
    sx = sm_r ? SIGN_BIT : '0;
    shift_big = (b_r[ALU_W-1:CNT_W] != '0);
  end

  // combinational ops and error cases, or hand off to the iterative core
  always_comb begin
    simple = '{value: '0, value_signed: sm_r, truth: 1'b0, error: ERR_NONE};
    need_core = 1'b0;
    kind = K_MUL;
    unique case (cmd_r) inside
      OP_ADD: simple.value = a_r + b_r;
      OP_SUB: simple.value = a_r - b_r;
      OP_MUL: need_core = 1'b1;
      OP_DIV, OP_MOD: begin
        if (b_r == '0) simple.error = ERR_DIV0;
        else begin
          need_core = 1'b1;
          kind = K_DIV;
        end
      end
      OP_POW: begin
        if (sm_r && nb) simple.error = ERR_NEGEXP;
        else begin
          need_core = 1'b1;
          kind = K_POW;
        end
      end
      OP_NEG: begin
        if (!sm_r) begin
          // unsigned above the signed minimum has no signed negative
          if (a_r > SIGN_BIT) begin
            simple.error = ERR_NEGRANGE;
            simple.value_signed = 1'b0;
          end else begin
            simple.value = neg(a_r);
            simple.value_signed = 1'b1;
          end
        end else if (a_r == SIGN_BIT) begin
          // signed minimum becomes unsigned 2^63
          simple.value = SIGN_BIT;
          simple.value_signed = 1'b0;
        end else begin
          simple.value = neg(a_r);
          simple.value_signed = 1'b1;
        end
      end
      OP_AND: simple.value = a_r & b_r;
      OP_OR:  simple.value = a_r | b_r;
      OP_XOR: simple.value = a_r ^ b_r;
      OP_NOT: simple.value = ~a_r;
      OP_SHL: simple.value = shift_big ? '0 : a_r << b_r[CNT_W-1:0];
      OP_SHR: simple.value = shift_big ? '0 : a_r >> b_r[CNT_W-1:0];
      OP_EQ:  simple.truth = (a_r == b_r);
      OP_LT:  simple.truth = ((a_r ^ sx) < (b_r ^ sx));
      OP_LE:  simple.truth = ((a_r ^ sx) <= (b_r ^ sx));
      default: ;
    endcase
  end

  // sign fixup of core results; min / -1 wraps back to min here
  always_comb begin
    cres = '{value: core_q, value_signed: sm_r, truth: 1'b0, error: ERR_NONE};
    case (cmd_r)
      OP_DIV:  cres.value = (sm_r && (na ^ nb)) ? neg(core_q) : core_q;
      OP_MOD:  cres.value = (sm_r && na) ? neg(core_r) : core_r;
      default: ;
    endcase
  end

  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: if (in_tvalid) st_nxt = S_EXEC;
      S_EXEC: st_nxt = need_core ? S_WAIT : S_DONE;
      S_WAIT: if (rsp.done) st_nxt = S_DONE;
      S_DONE: if (out_free) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready = (st_r == S_IDLE);
    req.start = (st_r == S_EXEC) && need_core;
    req.kind = kind;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == S_DONE && out_free) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      cmd_r <= op_t'(in_tuser[3:0]);
      sm_r <= in_tuser[4];
      a_r <= in_tdata[ALU_W-1:0];
      b_r <= in_tdata[2*ALU_W-1:ALU_W];
    end
    if (st_r == S_EXEC) res_r <= simple;
    else if (st_r == S_WAIT && rsp.done) res_r <= cres;
    if (st_r == S_DONE && out_free) out_r <= res_r;
  end

  i64alu_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .x     (kind == K_DIV ? ma : a_r),
    .y     (kind == K_DIV ? mb : b_r),
    .rsp   (rsp),
    .q     (core_q),
    .r     (core_r)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata = {{OUT_PAD_W{1'b0}}, out_r.error, out_r.truth, out_r.value};
  assign out_tuser = out_r.value_signed;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    st_r != S_IDLE |-> !in_tready) else $error("input ready while busy");
  a_wait_core: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_WAIT |-> rsp.busy) else $error("waiting on an idle core");

endmodule
`default_nettype wire

// ----- tb/int64_uint64_alu_unit_tb.sv -----
`timescale 1ns / 1ps
`default_nettype none
module int64_uint64_alu_unit_tb;
  import i64alu_pkg::*;

  // one pending operation as presented on the input channel
  typedef struct packed {
    op_t         op;
    logic        smode;
    logic [63:0] opa;
    logic [63:0] opb;
  } alu_req_t;

  // one expected result beat
  typedef struct packed {
    logic [63:0] value;
    logic        vsigned;
    logic        truth;
    err_t        error;
  } alu_res_t;

  localparam logic [63:0] MIN_S = 64'h8000000000000000;
  localparam logic [63:0] MAX_S = 64'h7FFFFFFFFFFFFFFF;
  localparam int          CYCLE_LIMIT = 2000000;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  wire          in_tready;
  logic [127:0] in_tdata;
  logic [4:0]   in_tuser;
  wire          out_tvalid;
  logic         out_tready;
  wire  [71:0]  out_tdata;
  wire          out_tuser;

  alu_req_t pending_ops[$];
  alu_res_t expected_results[$];
  int       mismatches = 0;
  int       cycles = 0;
  bit       stim_done = 1'b0;

  int       burst_left;
  int       gap_left;
  int       stall_phase;

  int64_uint64_alu_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // operand_a [63:0], operand_b [127:64]
    .in_tuser   (in_tuser),   // cmd [3:0], signed_mode [4]
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // value [63:0], truth [64], error [66:65], pad
    .out_tuser  (out_tuser)   // value_signed
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic logic [63:0] magnitude(input logic [63:0] x);
    return x[63] ? 64'd0 - x : x;
  endfunction

  // square-and-multiply over all 64 exponent bits, wrapping
  function automatic logic [63:0] power_mod(input logic [63:0] base, input logic [63:0] ex);
    logic [63:0] acc;
    logic [63:0] sq;
    acc = 64'd1;
    sq  = base;
    for (int i = 0; i < 64; i++) begin
      if (ex[i]) acc = acc * sq;
      sq = sq * sq;
    end
    return acc;
  endfunction

  // golden alu behavior
  function automatic alu_res_t compute_alu(input alu_req_t r);
    alu_res_t    res;
    logic [63:0] ca;
    logic [63:0] cb;
    logic [63:0] q;
    res.value   = '0;
    res.vsigned = r.smode;
    res.truth   = 1'b0;
    res.error   = ERR_NONE;
    // bias by the sign bit so an unsigned compare orders signed values
    ca = r.smode ? (r.opa ^ MIN_S) : r.opa;
    cb = r.smode ? (r.opb ^ MIN_S) : r.opb;
    case (r.op)
      OP_ADD: res.value = r.opa + r.opb;
      OP_SUB: res.value = r.opa - r.opb;
      OP_MUL: res.value = r.opa * r.opb;
      OP_DIV, OP_MOD: begin
        if (r.opb == 0) begin
          res.error = ERR_DIV0;
        end else if (!r.smode) begin
          res.value = (r.op == OP_DIV) ? r.opa / r.opb : r.opa % r.opb;
        end else if (r.op == OP_DIV) begin
          // min / -1 wraps back to min through the magnitude path
          q = magnitude(r.opa) / magnitude(r.opb);
          res.value = (r.opa[63] != r.opb[63]) ? 64'd0 - q : q;
        end else begin
          q = magnitude(r.opa) % magnitude(r.opb);
          res.value = r.opa[63] ? 64'd0 - q : q;
        end
      end
      OP_POW: begin
        if (r.smode && r.opb[63]) res.error = ERR_NEGEXP;
        else res.value = power_mod(r.opa, r.opb);
      end
      OP_NEG: begin
        if (!r.smode) begin
          if (r.opa > MIN_S) begin
            res.error   = ERR_NEGRANGE;
            res.vsigned = 1'b0;
          end else begin
            res.value   = 64'd0 - r.opa;
            res.vsigned = 1'b1;
          end
        end else if (r.opa == MIN_S) begin
          // signed minimum turns into unsigned 2^63
          res.value   = MIN_S;
          res.vsigned = 1'b0;
        end else begin
          res.value   = 64'd0 - r.opa;
          res.vsigned = 1'b1;
        end
      end
      OP_AND: res.value = r.opa & r.opb;
      OP_OR:  res.value = r.opa | r.opb;
      OP_XOR: res.value = r.opa ^ r.opb;
      OP_NOT: res.value = ~r.opa;
      OP_SHL: res.value = (r.opb >= 64) ? 64'd0 : r.opa << r.opb[5:0];
      OP_SHR: res.value = (r.opb >= 64) ? 64'd0 : r.opa >> r.opb[5:0];
      OP_EQ:  res.truth = (r.opa == r.opb);
      OP_LT:  res.truth = (ca < cb);
      default: res.truth = (ca <= cb);
    endcase
    return res;
  endfunction

  // operand picker weighted toward corner values
  function automatic logic [63:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 64'd0;
      1: return 64'hFFFFFFFFFFFFFFFF;
      2: return MIN_S;
      3: return MAX_S;
      4: return 64'($urandom_range(0, 8)) - 64'd4;
      5: return {$urandom, $urandom} >> $urandom_range(0, 63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic alu_req_t random_op();
    alu_req_t r;
    r.op    = op_t'($urandom_range(0, 15));
    r.smode = 1'($urandom_range(0, 1));
    r.opa   = pick_operand();
    r.opb   = pick_operand();
    case (r.op)
      // small shift counts mostly, with some out-of-range ones
      OP_SHL, OP_SHR: if ($urandom_range(0, 3) != 0) r.opb = 64'($urandom_range(0, 70));
      // small exponents keep pow latency sane, a few full width
      OP_POW: if ($urandom_range(0, 7) != 0) r.opb = 64'($urandom_range(0, 40));
      OP_NEG: if ($urandom_range(0, 3) == 0)
        r.opa = MIN_S + 64'($urandom_range(0, 2)) - 64'd1;
      OP_EQ, OP_LT, OP_LE: if ($urandom_range(0, 2) == 0) r.opb = r.opa;
      default: ;
    endcase
    return r;
  endfunction

  function automatic alu_req_t mk(input op_t op, input logic sm, input logic [63:0] a,
                                  input logic [63:0] b);
    alu_req_t r;
    r.op = op; r.smode = sm; r.opa = a; r.opb = b;
    return r;
  endfunction

  // stimulus: directed corner cases then random beats
  initial begin
    pending_ops.push_back(mk(OP_ADD, 1'b0, 64'hFFFFFFFFFFFFFFFF, 64'd1));
    pending_ops.push_back(mk(OP_SUB, 1'b1, MIN_S, 64'd1));
    pending_ops.push_back(mk(OP_MUL, 1'b1, MAX_S, 64'hFFFFFFFFFFFFFFFF));
    pending_ops.push_back(mk(OP_DIV, 1'b0, 64'd5, 64'd0));
    pending_ops.push_back(mk(OP_MOD, 1'b1, 64'd5, 64'd0));
    pending_ops.push_back(mk(OP_DIV, 1'b1, MIN_S, 64'hFFFFFFFFFFFFFFFF));
    pending_ops.push_back(mk(OP_MOD, 1'b1, MIN_S, 64'hFFFFFFFFFFFFFFFF));
    pending_ops.push_back(mk(OP_DIV, 1'b1, -64'sd7, 64'd2));
    pending_ops.push_back(mk(OP_MOD, 1'b1, -64'sd7, 64'd2));
    pending_ops.push_back(mk(OP_DIV, 1'b0, 64'hFFFFFFFFFFFFFFFF, 64'd3));
    pending_ops.push_back(mk(OP_POW, 1'b1, 64'd3, 64'hFFFFFFFFFFFFFFFF));
    pending_ops.push_back(mk(OP_POW, 1'b0, 64'd0, 64'd0));
    pending_ops.push_back(mk(OP_POW, 1'b0, 64'd3, 64'hFFFFFFFFFFFFFFFF));
    pending_ops.push_back(mk(OP_NEG, 1'b0, MIN_S + 64'd1, 64'd0));
    pending_ops.push_back(mk(OP_NEG, 1'b0, MIN_S, 64'd0));
    pending_ops.push_back(mk(OP_NEG, 1'b1, MIN_S, 64'd0));
    pending_ops.push_back(mk(OP_NEG, 1'b1, 64'd0, 64'd0));
    pending_ops.push_back(mk(OP_AND, 1'b0, 64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF));
    pending_ops.push_back(mk(OP_OR,  1'b1, 64'd0, MIN_S));
    pending_ops.push_back(mk(OP_XOR, 1'b0, MAX_S, 64'hFFFFFFFFFFFFFFFF));
    pending_ops.push_back(mk(OP_NOT, 1'b1, 64'd0, 64'hFFFFFFFFFFFFFFFF));
    pending_ops.push_back(mk(OP_SHL, 1'b1, 64'd1, 64'd63));
    pending_ops.push_back(mk(OP_SHR, 1'b1, MIN_S, 64'hFFFFFFFFFFFFFFFF));
    pending_ops.push_back(mk(OP_LT,  1'b1, MIN_S, MAX_S));
    pending_ops.push_back(mk(OP_LE,  1'b0, MIN_S, MAX_S));
    pending_ops.push_back(mk(OP_EQ,  1'b0, MAX_S, MAX_S));
    repeat (1200) pending_ops.push_back(random_op());
  end

  // driver: bursts of beats separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      in_tdata   <= '0;
      in_tuser   <= '0;
      burst_left <= 0;
      gap_left   <= 0;
    end else if (!in_tvalid || in_tready) begin
      // slot is free: current beat (if any) was taken at this edge
      if (in_tvalid) expected_results.push_back(compute_alu(pending_ops.pop_front()));
      if (gap_left > 0) begin
        gap_left  <= gap_left - 1;
        in_tvalid <= 1'b0;
      end else if (pending_ops.size() != 0) begin
        in_tvalid <= 1'b1;
        in_tdata  <= {pending_ops[0].opb, pending_ops[0].opa};
        in_tuser  <= {pending_ops[0].smode, pending_ops[0].op};
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_tvalid <= 1'b0;
        stim_done <= 1'b1;
      end
    end
  end

  // receiver back-pressure: cycles through free-running, lightly stalled and stall-heavy phases
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready  <= 1'b0;
      stall_phase <= 0;
    end else begin
      stall_phase <= stall_phase + 1;
      case ((stall_phase / 400) % 3)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 3) != 0);
        default: out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // monitor: check each result beat against the oldest expectation
  always @(posedge clk) begin
    alu_res_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result beat expected none actual value=%h", $time,
                 out_tdata[63:0]);
        mismatches++;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_tdata[63:0] !== exp_r.value) begin
          $display("%0t: value expected %h actual %h", $time, exp_r.value, out_tdata[63:0]);
          mismatches++;
        end
        if (out_tuser !== exp_r.vsigned) begin
          $display("%0t: value_signed expected %b actual %b", $time, exp_r.vsigned, out_tuser);
          mismatches++;
        end
        if (out_tdata[64] !== exp_r.truth) begin
          $display("%0t: truth expected %b actual %b", $time, exp_r.truth, out_tdata[64]);
          mismatches++;
        end
        if (out_tdata[66:65] !== exp_r.error) begin
          $display("%0t: error expected %0d actual %0d", $time, exp_r.error,
                   out_tdata[66:65]);
          mismatches++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("int64_uint64_alu_unit regression: fail");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    wait (stim_done && !in_tvalid && expected_results.size() == 0);
    // drain window for any stray late beat
    repeat (600) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("int64_uint64_alu_unit regression: pass");
    end else begin
      $display("int64_uint64_alu_unit regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
